// ===== hdl/spq_pkg.sv =====
// Shared types and constants of the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_W      = 8;
  localparam int PRIO_W      = 4;
  localparam int OCC_W       = 5;

  localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(9);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // One queue slot as it moves along the row.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Operation broadcast to every slot in the cycle a beat is accepted.
  typedef struct packed {
    logic              insert;
    logic              remove;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } op_t;

endpackage
`default_nettype wire

// ===== hdl/spq_req_if.sv =====
// Request channel: one queue command per beat.
`timescale 1ns / 1ps
`default_nettype none
interface spq_req_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [DATA_W-1:0] item_data;
  logic [PRIO_W-1:0] item_priority;

  modport source (output valid, cmd, item_data, item_priority, input ready);
  modport sink   (input valid, cmd, item_data, item_priority, output ready);
endinterface
`default_nettype wire

// ===== hdl/spq_rsp_if.sv =====
// Response channel: one result per command beat.
`timescale 1ns / 1ps
`default_nettype none
interface spq_rsp_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  logic [PRIO_W-1:0] out_priority;
  logic [1:0]        status;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, out_valid, out_data, out_priority, status, occupancy,
                  input ready);
  modport sink   (input valid, out_valid, out_data, out_priority, status, occupancy,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/spq_slot.sv =====
// One slot of the sorted row: holds, takes the new item, or shifts from a neighbor.
`timescale 1ns / 1ps
`default_nettype none
module spq_slot
  import spq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire op_t    op,
  input  wire entry_t left,
  input  wire logic   left_keep,
  input  wire entry_t right,
  output entry_t      slot,
  output logic        keep
);

  entry_t slot_next;

  // A slot keeps its item on insert when it outranks or ties the new one,
  // so equal priorities stay first in, first out.
  assign keep = slot.valid && (slot.prio >= op.prio);

  always_comb begin
    slot_next = slot;
    if (op.insert) begin
      if (keep) begin
        slot_next = slot;
      end else if (left_keep) begin
        slot_next.valid = 1'b1;
        slot_next.data  = op.data;
        slot_next.prio  = op.prio;
      end else begin
        slot_next = left;
      end
    end else if (op.remove) begin
      slot_next = right;
    end
  end

  // Only the valid bit needs a reset; payload of an empty slot is never shown.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.data <= slot_next.data;
    slot.prio <= slot_next.prio;
  end

endmodule
`default_nettype wire

// ===== hdl/stable_priority_queue.sv =====
// Stable priority queue built as a row of shifting slots.
//
// The req channel carries one command per beat: insert (item_data with
// item_priority) or remove. The rsp channel returns exactly one result beat
// per command, in order: the removed item on a successful remove, a status
// code, and the occupancy after the command.
//
// Every slot compares its priority with the new one at the same time and
// either holds, takes the new item or copies its neighbor, so each command
// finishes in the cycle it is accepted. The result is registered and shows
// on rsp in the cycle after acceptance. A new command is taken every cycle as
// long as the result register is empty or being drained in that cycle.
//
// Reset empties the queue and drops any pending result; no clearing pass
// is needed. When the receiver stalls, the result register holds its beat
// and req.ready falls until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_queue
  import spq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam logic [OCC_W-1:0] OCC_ONE = OCC_W'(1);

  entry_t            slots [QUEUE_DEPTH];
  logic              keeps [QUEUE_DEPTH];
  op_t               op;
  logic              accept;
  logic              full;
  logic              empty;
  logic [PRIO_W-1:0] prio_clamped;
  logic [OCC_W-1:0]  count;
  logic [OCC_W-1:0]  count_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = slots[QUEUE_DEPTH-1].valid;
  assign empty     = !slots[0].valid;

  always_comb begin
    if (req.item_priority < PRIO_MIN) begin
      prio_clamped = PRIO_MIN;
    end else if (req.item_priority > PRIO_MAX) begin
      prio_clamped = PRIO_MAX;
    end else begin
      prio_clamped = req.item_priority;
    end
  end

  always_comb begin
    op.insert = accept && (req.cmd == CMD_INSERT) && !full;
    op.remove = accept && (req.cmd == CMD_REMOVE) && !empty;
    op.data   = req.item_data;
    op.prio   = prio_clamped;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_row
    entry_t left_entry;
    entry_t right_entry;
    logic   left_keep;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_keep  = 1'b1;
    end else begin : g_body
      assign left_entry = slots[i-1];
      assign left_keep  = keeps[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = slots[i+1];
    end

    spq_slot u_slot (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .left      (left_entry),
      .left_keep (left_keep),
      .right     (right_entry),
      .slot      (slots[i]),
      .keep      (keeps[i])
    );
  end

  always_comb begin
    count_next = count;
    if (op.insert) begin
      count_next = count + OCC_ONE;
    end else if (op.remove) begin
      count_next = count - OCC_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.out_valid    <= op.remove;
      rsp.out_data     <= op.remove ? slots[0].data : '0;
      rsp.out_priority <= op.remove ? slots[0].prio : '0;
      rsp.occupancy    <= count_next;
      if ((req.cmd == CMD_REMOVE) && empty) begin
        rsp.status <= STATUS_EMPTY;
      end else if ((req.cmd == CMD_INSERT) && full) begin
        rsp.status <= STATUS_FULL;
      end else begin
        rsp.status <= STATUS_OK;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/spq_checker.sv =====
// Port-level checks of the stable priority queue and their binding.
`timescale 1ns / 1ps
`default_nettype none
module spq_checker
  import spq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic              out_valid,
  input wire logic [DATA_W-1:0] out_data,
  input wire logic [PRIO_W-1:0] out_priority,
  input wire logic [1:0]        status,
  input wire logic [OCC_W-1:0]  occupancy
);

  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(out_valid) && $stable(out_data) && $stable(out_priority) &&
      $stable(status) && $stable(occupancy))
    else $error("result beat changed while stalled");

  // Nothing is shown in the cycle after reset.
  assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result beat right after reset");

  // A returned item only comes with an ok status.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_valid |-> status == STATUS_OK)
    else $error("returned item with an error status");

  // A failed remove leaves an empty queue and returns nothing.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STATUS_EMPTY) |->
      (occupancy == '0) && !out_valid && (out_data == '0) && (out_priority == '0))
    else $error("empty report with stored items or data");

  // A dropped insert means the queue is full.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STATUS_FULL) |-> occupancy == OCC_FULL)
    else $error("full report with free slots");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .out_valid    (rsp.out_valid),
  .out_data     (rsp.out_data),
  .out_priority (rsp.out_priority),
  .status       (rsp.status),
  .occupancy    (rsp.occupancy)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the stable priority queue with a command-level queue predictor.
`timescale 1ns / 1ps
module tb;
  import spq_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 850;
  localparam int CHUNK_ITEMS  = 50;

  typedef struct packed {
    logic              removed;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
    status_t           status;
    logic [OCC_W-1:0]  occ;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  stable_priority_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted queue contents, slot 0 is the head.
  logic [DATA_W-1:0] queue_data [QUEUE_DEPTH];
  logic [PRIO_W-1:0] queue_prio [QUEUE_DEPTH];
  int                queue_count = 0;

  queue_result_t pending_results [$];
  int            mismatch_count = 0;
  int            idle_cycles = 0;

  bit gaps_on   = 1'b0;
  bit stalls_on = 1'b0;
  int burst_left = 0;

  function automatic queue_result_t apply_queue_op(cmd_t op, logic [DATA_W-1:0] data,
                                                   logic [PRIO_W-1:0] prio);
    queue_result_t     res;
    logic [PRIO_W-1:0] eff_prio;
    int                pos;
    res.removed = 1'b0;
    res.data    = '0;
    res.prio    = '0;
    res.status  = STATUS_OK;
    if (op == CMD_INSERT) begin
      eff_prio = prio;
      if (prio < PRIO_MIN) eff_prio = PRIO_MIN;
      else if (prio > PRIO_MAX) eff_prio = PRIO_MAX;
      if (queue_count >= QUEUE_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        // The new item goes behind every item of equal or higher priority.
        pos = 0;
        while (pos < queue_count && queue_prio[pos] >= eff_prio) pos++;
        for (int i = queue_count; i > pos; i--) begin
          queue_data[i] = queue_data[i-1];
          queue_prio[i] = queue_prio[i-1];
        end
        queue_data[pos] = data;
        queue_prio[pos] = eff_prio;
        queue_count++;
      end
    end else begin
      if (queue_count == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.removed = 1'b1;
        res.data    = queue_data[0];
        res.prio    = queue_prio[0];
        for (int i = 0; i + 1 < queue_count; i++) begin
          queue_data[i] = queue_data[i+1];
          queue_prio[i] = queue_prio[i+1];
        end
        queue_count--;
      end
    end
    res.occ = OCC_W'(queue_count);
    return res;
  endfunction

  function automatic void compare_field(string name, int unsigned expv, int unsigned actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expv, actv);
      mismatch_count++;
    end
  endfunction

  // Response checking first, then prediction of the command accepted at the same edge,
  // all in one process so the order within the time step does not matter.
  always @(posedge clk) begin
    queue_result_t exp_res;
    bit            moved;
    moved = 1'b0;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual data %0h status %0h",
                   $time, rsp_ch.out_data, rsp_ch.status);
          mismatch_count++;
        end else begin
          exp_res = pending_results.pop_front();
          compare_field("out_valid", exp_res.removed, rsp_ch.out_valid);
          compare_field("out_data", exp_res.data, rsp_ch.out_data);
          compare_field("out_priority", exp_res.prio, rsp_ch.out_priority);
          compare_field("status", exp_res.status, rsp_ch.status);
          compare_field("occupancy", exp_res.occ, rsp_ch.occupancy);
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        moved = 1'b1;
        pending_results.push_back(apply_queue_op(cmd_t'(req_ch.cmd), req_ch.item_data,
                                                 req_ch.item_priority));
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver back-pressure follows a random bit pattern, reloaded once all its bits are used.
  always @(negedge clk) begin
    logic [7:0] stall_pattern;
    int         stall_phase;
    if (!stalls_on) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      if (stall_phase == 0) stall_pattern = 8'($urandom);
      rsp_ch.ready <= stall_pattern[stall_phase];
      stall_phase = (stall_phase + 1) % 8;
    end
  end

  task automatic send_command(cmd_t op, logic [DATA_W-1:0] data, logic [PRIO_W-1:0] prio);
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= op;
    req_ch.item_data     <= data;
    req_ch.item_priority <= prio;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic set_idling();
    gaps_on   = ($urandom_range(0, 2) != 0);
    stalls_on = ($urandom_range(0, 2) != 0);
  endtask

  task automatic test_remove_on_empty();
    send_command(CMD_REMOVE, 8'hFF, 4'hF);
  endtask

  // Out-of-range priorities are clamped, extreme payloads pass through unchanged.
  task automatic test_priority_clamp();
    send_command(CMD_INSERT, 8'h00, 4'd0);
    send_command(CMD_INSERT, 8'hFF, 4'd15);
    send_command(CMD_INSERT, 8'hA5, PRIO_MAX);
    send_command(CMD_INSERT, 8'h5A, PRIO_MIN);
    repeat (4) send_command(CMD_REMOVE, 8'h00, 4'd0);
  endtask

  // Fill with few distinct priorities so ties are common, then overflow by one.
  task automatic test_fill_and_drop();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_command(CMD_INSERT, 8'($urandom), 4'($urandom_range(1, 3)));
    end
    send_command(CMD_INSERT, 8'h3C, 4'd7);
  endtask

  task automatic test_random_mix();
    int   insert_pct;
    cmd_t op;
    logic [PRIO_W-1:0] prio;
    for (int chunk = 0; chunk < RANDOM_ITEMS / CHUNK_ITEMS; chunk++) begin
      set_idling();
      case ($urandom_range(0, 2))
        0: insert_pct = 25;
        1: insert_pct = 50;
        default: insert_pct = 75;
      endcase
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        op = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        if ($urandom_range(0, 9) == 0) prio = 4'($urandom_range(0, 15));
        else prio = 4'($urandom_range(1, 9));
        send_command(op, 8'($urandom), prio);
      end
    end
  endtask

  task automatic finish_stimulus();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.cmd           = CMD_INSERT;
    req_ch.item_data     = '0;
    req_ch.item_priority = '0;
    rsp_ch.ready         = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_remove_on_empty();
    stalls_on = 1'b1;
    test_priority_clamp();
    gaps_on = 1'b1;
    test_fill_and_drop();
    test_random_mix();
    finish_stimulus();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
